>>> rtl/smt_pkg.sv
package smt_pkg;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ZDIV,
		ST_ZWAIT,
		ST_ZCHK,
		ST_XDIV,
		ST_XWAIT,
		ST_YMUL,
		ST_YDIV,
		ST_YWAIT,
		ST_MAC,
		ST_MACEND,
		ST_WSUM,
		ST_DONE
	} smt_state_t;

	// Result status codes.
	typedef enum logic [2:0] {
		STATUS_OK      = 3'd0,
		STATUS_DIST    = 3'd1,
		STATUS_TRACKED = 3'd2,
		STATUS_DISP    = 3'd3,
		STATUS_DEPTH   = 3'd4
	} smt_status_t;

	// Input commands.
	localparam logic CMD_POSE  = 1'b0;
	localparam logic CMD_MATCH = 1'b1;

	// Configuration register indexes.
	localparam logic [2:0] REG_FOCAL_X  = 3'd0;
	localparam logic [2:0] REG_FOCAL_Y  = 3'd1;
	localparam logic [2:0] REG_CENTER_X = 3'd2;
	localparam logic [2:0] REG_CENTER_Y = 3'd3;
	localparam logic [2:0] REG_BASELINE = 3'd4;
	localparam logic [2:0] REG_MIN_DISP = 3'd5;
	localparam logic [2:0] REG_NEAR     = 3'd6;
	localparam logic [2:0] REG_FAR      = 3'd7;

	// Configuration reset values.
	localparam logic [19:0] RST_FOCAL_X  = 20'd8000;
	localparam logic [19:0] RST_FOCAL_Y  = 20'd8000;
	localparam logic [15:0] RST_CENTER_X = 16'd5120;
	localparam logic [15:0] RST_CENTER_Y = 16'd3840;
	localparam logic [19:0] RST_BASELINE = 20'd7864;
	localparam logic [15:0] RST_MIN_DISP = 16'd48;
	localparam logic [23:0] RST_NEAR     = 24'd6554;
	localparam logic [23:0] RST_FAR      = 24'd327680;

	localparam logic [8:0]  MAX_DISTANCE = 9'd50;
	localparam int          POSE_WORDS   = 12;
	localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

	// Shared unit widths.
	localparam int DIV_W = 40;
	localparam int DVS_W = 20;
	localparam int MUL_W = 33;

	localparam logic signed [63:0] W40_MAX = 64'sd549755813887;
	localparam logic signed [63:0] W40_MIN = -64'sd549755813888;

	localparam int DEF_ID_WIDTH           = 32;
	localparam int DEF_FEATURE_INDEX_BITS = 12;

	// Row of a rotation element in row-major order.
	function automatic logic [1:0] elem_row(input logic [3:0] e);
		logic [1:0] r;
		unique case (e)
			4'd0, 4'd1, 4'd2: r = 2'd0;
			4'd3, 4'd4, 4'd5: r = 2'd1;
			default:          r = 2'd2;
		endcase
		return r;
	endfunction

	// Column of a rotation element in row-major order.
	function automatic logic [1:0] elem_col(input logic [3:0] e);
		logic [1:0] c;
		unique case (e)
			4'd0, 4'd3, 4'd6: c = 2'd0;
			4'd1, 4'd4, 4'd7: c = 2'd1;
			default:          c = 2'd2;
		endcase
		return c;
	endfunction

endpackage

>>> rtl/smt_div.sv
module smt_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [smt_pkg::DIV_W-1:0]    dividend,
	input  logic [smt_pkg::DVS_W-1:0]    divisor,
	output logic                         busy,
	output logic                         done,
	output logic [smt_pkg::DIV_W-1:0]    quotient
);

	localparam int CNT_W = $clog2(smt_pkg::DIV_W + 1);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [smt_pkg::DIV_W-1:0]   dq_q;
	logic [smt_pkg::DVS_W:0]     rem_q;
	logic [smt_pkg::DVS_W-1:0]   dvs_q;
	logic [smt_pkg::DVS_W:0]     trial;
	logic                        ge;

	// One quotient bit per cycle, restoring.
	assign trial = {rem_q[smt_pkg::DVS_W-1:0], dq_q[smt_pkg::DIV_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(smt_pkg::DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? (trial - {1'b0, dvs_q}) : trial;
			dq_q  <= {dq_q[smt_pkg::DIV_W-2:0], ge};
		end
	end

	// A zero divisor gives a zero quotient.
	assign quotient = (dvs_q == '0) ? '0 : dq_q;
	assign busy     = busy_q;
	assign done     = done_q;

endmodule

>>> rtl/smt_mul.sv
module smt_mul (
	input  logic                                clk,
	input  logic signed [smt_pkg::MUL_W-1:0]    a,
	input  logic signed [smt_pkg::MUL_W-1:0]    b,
	output logic signed [2*smt_pkg::MUL_W-1:0]  p_s1
);

	// Signed multiply with the product registered.
	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end

endmodule

>>> rtl/stereo_match_triangulation.sv
// Stereo match triangulation. A pose load (command 0) writes one pose word. A
// match (command 1) rejected by the distance, tracking or disparity checks goes
// from the check state straight to done; a match that reaches the depth test is
// rejected there after the depth division, while an accepted match goes on to
// the X and Y divisions (with depth, three on the shared radix-2 divider) and
// then 18 issues of the shared 33x33 multiplier for the pose rotation. One
// match is in flight at a time; s_tready is high only while the sequencer is
// idle, and a finished result waits in the output register for m_tready. World
// coordinates saturate to 40 bits; rejected matches report zero ID and zero
// coordinates.
module stereo_match_triangulation #(
	parameter int ID_WIDTH           = smt_pkg::DEF_ID_WIDTH,
	parameter int FEATURE_INDEX_BITS = smt_pkg::DEF_FEATURE_INDEX_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [23:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pose_index[3:0], pose_value[35:4], match_distance[44:36],
	// already_tracked[45], feature_index[57:46], left_x[73:58],
	// left_y[89:74], right_x[105:90], zero fill
	input  logic [111:0] s_tdata,
	// command[0]
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// match_feature[11:0], landmark_id[43:12], world_x[83:44],
	// world_y[123:84], world_z[163:124], zero fill
	output logic [167:0] m_tdata,
	// status[2:0]
	output logic [2:0]   m_tuser
);

	localparam logic [11:0] FEAT_MASK = (FEATURE_INDEX_BITS >= 12) ? 12'hFFF :
		12'((1 << FEATURE_INDEX_BITS) - 1);
	localparam int MW = smt_pkg::MUL_W;

	smt_pkg::smt_state_t state_q, state_d;

	// Configuration registers.
	logic [19:0] focal_x_q, focal_y_q, baseline_q;
	logic [15:0] center_x_q, center_y_q, min_disp_q;
	logic [23:0] near_q, far_q;

	logic signed [31:0] pose_q [smt_pkg::POSE_WORDS];
	logic [ID_WIDTH-1:0] next_id_q;

	// Latched match.
	logic [8:0]  dist_q;
	logic        tracked_q;
	logic [11:0] feat_q;
	logic [15:0] lx_q, ly_q, rx_q;

	logic [39:0]        z_q;
	logic               neg_q;
	logic signed [40:0] p_q [2];
	logic [4:0]         step_q;
	logic [1:0]         row_q;
	logic signed [63:0] hi_q [3];
	logic signed [63:0] lo_q [3];
	logic signed [39:0] world_q [3];
	smt_pkg::smt_status_t status_q;

	// Multiplier tag, registered alongside the product.
	logic       tag_v_s1;
	logic [1:0] tag_row_s1;
	logic       tag_half_s1;

	// Output register.
	logic                 out_valid_q;
	smt_pkg::smt_status_t out_status_q;
	logic [11:0]          out_feat_q;
	logic [31:0]          out_id_q;
	logic signed [39:0]   out_world_q [3];

	logic                         in_acc;
	logic                         out_load;
	logic signed [16:0]           disp;
	smt_pkg::smt_status_t         chk_status;
	logic                         chk_pass;
	logic signed [MW-1:0]         mul_a, mul_b;
	logic signed [2*MW-1:0]       mul_p;
	logic                         div_start, div_busy, div_done;
	logic [smt_pkg::DIV_W-1:0]    div_dvd, div_quo;
	logic [smt_pkg::DVS_W-1:0]    div_dvs;
	logic [2*MW-1:0]              mag;
	logic signed [40:0]           p_signed;
	logic [3:0]                   elem;
	logic [1:0]                   col;
	logic signed [40:0]           p_sel;
	logic signed [63:0]           wsum;
	logic signed [39:0]           wsat;
	logic [31:0]                  id32;
	logic                         z_out;

	assign in_acc   = s_tvalid && s_tready;
	assign s_tready = (state_q == smt_pkg::ST_IDLE);
	assign out_load = (state_q == smt_pkg::ST_DONE) && (!out_valid_q || m_tready);

	// Match checks in their fixed order.
	assign disp = $signed({1'b0, lx_q}) - $signed({1'b0, rx_q});
	always_comb begin
		priority if (dist_q > smt_pkg::MAX_DISTANCE) begin
			chk_status = smt_pkg::STATUS_DIST;
		end else if (tracked_q) begin
			chk_status = smt_pkg::STATUS_TRACKED;
		end else if (disp <= 17'sd0 || disp[15:0] < min_disp_q) begin
			chk_status = smt_pkg::STATUS_DISP;
		end else begin
			chk_status = smt_pkg::STATUS_OK;
		end
	end
	assign chk_pass = (chk_status == smt_pkg::STATUS_OK);
	assign z_out    = (z_q < {16'd0, near_q}) || (z_q > {16'd0, far_q});

	// Magnitude of a signed product and signing of a quotient.
	assign mag      = mul_p[2*MW-1] ? (2*MW)'(-mul_p) : mul_p;
	assign p_signed = neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

	// Rotation element selection for the multiply-accumulate steps.
	assign elem  = step_q[4:1];
	assign col   = smt_pkg::elem_col(elem);
	assign p_sel = (col == 2'd2) ? $signed({17'd0, z_q[23:0]}) : p_q[col[0]];

	// World sum of the current row with saturation.
	assign wsum = hi_q[row_q] + (lo_q[row_q] >>> 16) + 64'(pose_q[4'd9 + 4'(row_q)]);
	always_comb begin
		priority if (wsum > smt_pkg::W40_MAX) begin
			wsat = 40'(smt_pkg::W40_MAX);
		end else if (wsum < smt_pkg::W40_MIN) begin
			wsat = 40'(smt_pkg::W40_MIN);
		end else begin
			wsat = 40'(wsum);
		end
	end

	generate
		if (ID_WIDTH >= 32) begin : g_id_wide
			assign id32 = next_id_q[31:0];
		end else begin : g_id_narrow
			assign id32 = 32'(next_id_q);
		end
	endgenerate

	smt_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.p_s1 (mul_p)
	);

	smt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and shared unit operands.
	always_comb begin
		state_d   = state_q;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = '0;
		unique case (state_q)
			smt_pkg::ST_IDLE: begin
				if (in_acc && s_tuser == smt_pkg::CMD_MATCH) begin
					state_d = smt_pkg::ST_CHECK;
				end
			end
			smt_pkg::ST_CHECK: begin
				mul_a   = $signed(MW'(focal_x_q));
				mul_b   = $signed(MW'(baseline_q));
				state_d = chk_pass ? smt_pkg::ST_ZDIV : smt_pkg::ST_DONE;
			end
			smt_pkg::ST_ZDIV: begin
				div_start = 1'b1;
				div_dvd   = mul_p[39:0];
				div_dvs   = {4'd0, disp[15:0]};
				state_d   = smt_pkg::ST_ZWAIT;
			end
			smt_pkg::ST_ZWAIT: begin
				if (div_done) begin
					state_d = smt_pkg::ST_ZCHK;
				end
			end
			smt_pkg::ST_ZCHK: begin
				mul_a   = MW'($signed({1'b0, lx_q}) - $signed({1'b0, center_x_q}));
				mul_b   = $signed(MW'(z_q[23:0]));
				state_d = z_out ? smt_pkg::ST_DONE : smt_pkg::ST_XDIV;
			end
			smt_pkg::ST_XDIV: begin
				div_start = 1'b1;
				div_dvd   = mag[39:0];
				div_dvs   = focal_x_q;
				state_d   = smt_pkg::ST_XWAIT;
			end
			smt_pkg::ST_XWAIT: begin
				if (div_done) begin
					state_d = smt_pkg::ST_YMUL;
				end
			end
			smt_pkg::ST_YMUL: begin
				mul_a   = MW'($signed({1'b0, ly_q}) - $signed({1'b0, center_y_q}));
				mul_b   = $signed(MW'(z_q[23:0]));
				state_d = smt_pkg::ST_YDIV;
			end
			smt_pkg::ST_YDIV: begin
				div_start = 1'b1;
				div_dvd   = mag[39:0];
				div_dvs   = focal_y_q;
				state_d   = smt_pkg::ST_YWAIT;
			end
			smt_pkg::ST_YWAIT: begin
				if (div_done) begin
					state_d = smt_pkg::ST_MAC;
				end
			end
			smt_pkg::ST_MAC: begin
				// Even steps take the low 16 bits, odd steps the high part.
				mul_a = MW'(pose_q[elem]);
				mul_b = step_q[0] ? MW'(p_sel >>> 16) : $signed(MW'(p_sel[15:0]));
				if (step_q == 5'd17) begin
					state_d = smt_pkg::ST_MACEND;
				end
			end
			smt_pkg::ST_MACEND: begin
				state_d = smt_pkg::ST_WSUM;
			end
			smt_pkg::ST_WSUM: begin
				if (row_q == 2'd2) begin
					state_d = smt_pkg::ST_DONE;
				end
			end
			smt_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = smt_pkg::ST_IDLE;
				end
			end
			default: state_d = smt_pkg::ST_IDLE;
		endcase
	end

	// Configuration, pose store, landmark counter and multiplier tag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= smt_pkg::RST_FOCAL_X;
			focal_y_q  <= smt_pkg::RST_FOCAL_Y;
			center_x_q <= smt_pkg::RST_CENTER_X;
			center_y_q <= smt_pkg::RST_CENTER_Y;
			baseline_q <= smt_pkg::RST_BASELINE;
			min_disp_q <= smt_pkg::RST_MIN_DISP;
			near_q     <= smt_pkg::RST_NEAR;
			far_q      <= smt_pkg::RST_FAR;
			for (int i = 0; i < smt_pkg::POSE_WORDS; i++) begin
				pose_q[i] <= (i == 0 || i == 4 || i == 8) ? smt_pkg::ONE_Q16 : 32'sd0;
			end
			next_id_q   <= '0;
			tag_v_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					smt_pkg::REG_FOCAL_X:  focal_x_q  <= cfg_data[19:0];
					smt_pkg::REG_FOCAL_Y:  focal_y_q  <= cfg_data[19:0];
					smt_pkg::REG_CENTER_X: center_x_q <= cfg_data[15:0];
					smt_pkg::REG_CENTER_Y: center_y_q <= cfg_data[15:0];
					smt_pkg::REG_BASELINE: baseline_q <= cfg_data[19:0];
					smt_pkg::REG_MIN_DISP: min_disp_q <= cfg_data[15:0];
					smt_pkg::REG_NEAR:     near_q     <= cfg_data[23:0];
					smt_pkg::REG_FAR:      far_q      <= cfg_data[23:0];
					default: ;
				endcase
			end
			// Pose load; slots past the translation words are ignored.
			if (in_acc && s_tuser == smt_pkg::CMD_POSE && s_tdata[3:0] < 4'd12) begin
				pose_q[s_tdata[3:0]] <= $signed(s_tdata[35:4]);
			end
			tag_v_s1 <= (state_q == smt_pkg::ST_MAC);
			if (out_load && status_q == smt_pkg::STATUS_OK) begin
				next_id_q <= next_id_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		tag_row_s1  <= smt_pkg::elem_row(elem);
		tag_half_s1 <= step_q[0];
		unique case (state_q)
			smt_pkg::ST_IDLE: begin
				dist_q    <= s_tdata[44:36];
				tracked_q <= s_tdata[45];
				feat_q    <= s_tdata[57:46] & FEAT_MASK;
				lx_q      <= s_tdata[73:58];
				ly_q      <= s_tdata[89:74];
				rx_q      <= s_tdata[105:90];
			end
			smt_pkg::ST_CHECK: begin
				status_q <= chk_status;
			end
			smt_pkg::ST_ZWAIT: begin
				if (div_done) begin
					z_q <= div_quo;
				end
			end
			smt_pkg::ST_ZCHK: begin
				if (z_out) begin
					status_q <= smt_pkg::STATUS_DEPTH;
				end
				for (int r = 0; r < 3; r++) begin
					hi_q[r] <= '0;
					lo_q[r] <= '0;
				end
			end
			smt_pkg::ST_XDIV, smt_pkg::ST_YDIV: begin
				neg_q <= mul_p[2*MW-1];
			end
			smt_pkg::ST_XWAIT: begin
				if (div_done) begin
					p_q[0] <= p_signed;
				end
			end
			smt_pkg::ST_YWAIT: begin
				if (div_done) begin
					p_q[1] <= p_signed;
				end
				step_q <= '0;
			end
			smt_pkg::ST_MAC: begin
				step_q <= step_q + 1'b1;
				row_q  <= '0;
			end
			smt_pkg::ST_WSUM: begin
				world_q[row_q] <= wsat;
				row_q          <= row_q + 1'b1;
			end
			default: ;
		endcase
		// Accumulate the registered multiplier product, steered by its tag.
		if (tag_v_s1) begin
			if (tag_half_s1) begin
				hi_q[tag_row_s1] <= hi_q[tag_row_s1] + 64'(mul_p);
			end else begin
				lo_q[tag_row_s1] <= lo_q[tag_row_s1] + 64'(mul_p);
			end
		end
		// Result word.
		if (out_load) begin
			out_status_q <= status_q;
			out_feat_q   <= feat_q;
			for (int r = 0; r < 3; r++) begin
				out_world_q[r] <= (status_q == smt_pkg::STATUS_OK) ? world_q[r] : 40'sd0;
			end
			out_id_q <= (status_q == smt_pkg::STATUS_OK) ? id32 : 32'd0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {4'd0, out_world_q[2], out_world_q[1], out_world_q[0],
		out_id_q, out_feat_q};

	// An accepted result advances the landmark counter by exactly one.
	a_id_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && status_q == smt_pkg::STATUS_OK) |=>
		(next_id_q == $past(next_id_q) + 1'b1))
		else $error("landmark counter did not advance on an accepted match");

	// The divider is never restarted while it is still working.
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	// A rejected match carries no ID and no coordinates.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != smt_pkg::STATUS_OK) |-> (m_tdata[163:12] == '0))
		else $error("rejected match carries a nonzero payload");

endmodule
